### src/sliding_window_rate_limiter_unit_macros.svh
// assertion macros for the sliding window rate limiter
`ifndef SLIDING_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SWRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define SWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWRL_ASSERT(lbl, prop, msg)
`define SWRL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/swrl_pkg.sv
// shared constants, types and helpers of the sliding window rate limiter
`timescale 1ns / 1ps

package swrl_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int ADDR_W       = $clog2(RING_DEPTH);
    localparam int CNT_RAW_W    = $clog2(RING_DEPTH + 1);
    localparam int LIVE_W       = 7;
    localparam int LIVE_MAX     = (1 << LIVE_W) - 1;
    localparam int CNT_W        = (CNT_RAW_W > LIVE_W) ? CNT_RAW_W : LIVE_W;
    localparam int TS_W         = 63;
    localparam int LIMIT_W      = 8;
    localparam int WINDOW_W     = 32;
    localparam int USEC_PER_SEC = 1000000;
    localparam int USEC_W       = 20;
    localparam int SPAN_W       = WINDOW_W + USEC_W;
    localparam int SUM_W        = 64;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 3;

    typedef enum logic [0:0] {
        REG_MAX_FAILURES   = 1'b0,
        REG_WINDOW_SECONDS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [LIMIT_W-1:0] max_failures;
        logic [WINDOW_W-1:0]       window_seconds;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] ring_advance(input logic [ADDR_W-1:0] pos);
        ring_advance = (pos == ADDR_W'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    function automatic logic [LIVE_W-1:0] live_sat(input logic [CNT_W-1:0] cnt);
        live_sat = (cnt > CNT_W'(LIVE_MAX)) ? LIVE_W'(LIVE_MAX) : cnt[LIVE_W-1:0];
    endfunction

endpackage

### src/swrl_core.sv
// stamp ring memory, drop scan and grant decision
`timescale 1ns / 1ps
`include "sliding_window_rate_limiter_unit_macros.svh"

module swrl_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swrl_pkg::cfg_t               cfg,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [swrl_pkg::TS_W-1:0]    timestamp,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         granted,
    output logic [swrl_pkg::LIVE_W-1:0]  live_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } state_t;

    state_t                          state_reg;
    logic [swrl_pkg::ADDR_W-1:0]     oldest_reg;
    logic [swrl_pkg::ADDR_W-1:0]     next_pos_reg;
    logic [swrl_pkg::CNT_W-1:0]      count_reg;
    logic [swrl_pkg::CNT_W-1:0]      count_next;
    logic                            rsp_valid_reg;
    logic                            granted_reg;
    logic [swrl_pkg::LIVE_W-1:0]     live_reg;

    logic [swrl_pkg::TS_W-1:0]       ts_reg;
    logic [swrl_pkg::SPAN_W-1:0]     span_reg;
    logic [swrl_pkg::TS_W-1:0]       rd_data_reg;
    logic [swrl_pkg::TS_W-1:0]       ring_mem [swrl_pkg::RING_DEPTH];

    logic [swrl_pkg::ADDR_W-1:0]     rd_addr;
    logic                            stale;
    logic                            out_free;
    logic                            limited;
    logic                            limit_hit;
    logic                            pop;
    logic                            commit;
    logic                            do_write;
    logic                            grant_now;

    always_comb
    begin
        stale     = (count_reg != '0) &&
                    ((swrl_pkg::SUM_W'(rd_data_reg) + swrl_pkg::SUM_W'(span_reg))
                     <= swrl_pkg::SUM_W'(ts_reg));
        out_free  = !rsp_valid_reg || !rsp_stall;
        limited   = !cfg.max_failures[swrl_pkg::LIMIT_W-1];
        limit_hit = (count_reg >= swrl_pkg::CNT_W'(cfg.max_failures[swrl_pkg::LIMIT_W-2:0])) ||
                    (count_reg == swrl_pkg::CNT_W'(swrl_pkg::RING_DEPTH));
        pop       = (state_reg == S_SCAN) && stale;
        commit    = (state_reg == S_SCAN) && !stale && out_free;
        do_write  = commit && limited && !limit_hit;
        grant_now = !limited || !limit_hit;
        count_next = do_write ? count_reg + 1'b1 : count_reg;
        rd_addr   = pop ? swrl_pkg::ring_advance(oldest_reg) : oldest_reg;
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ring_mem[next_pos_reg] <= ts_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            ts_reg   <= timestamp;
            span_reg <= swrl_pkg::SPAN_W'(cfg.window_seconds) *
                        swrl_pkg::SPAN_W'(swrl_pkg::USEC_PER_SEC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            next_pos_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            granted_reg   <= 1'b0;
            live_reg      <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !commit)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (pop)
                    begin
                        oldest_reg <= swrl_pkg::ring_advance(oldest_reg);
                        count_reg  <= count_reg - 1'b1;
                    end
                    else if (commit)
                    begin
                        if (do_write)
                        begin
                            next_pos_reg <= swrl_pkg::ring_advance(next_pos_reg);
                        end
                        count_reg     <= count_next;
                        rsp_valid_reg <= 1'b1;
                        granted_reg   <= grant_now;
                        live_reg      <= swrl_pkg::live_sat(count_next);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign granted    = granted_reg;
    assign live_count = live_reg;

    `SWRL_ASSERT(a_count_bound, count_reg <= swrl_pkg::CNT_W'(swrl_pkg::RING_DEPTH), "stored count above ring depth")
    `SWRL_ASSERT_NEXT(a_write_count, do_write, count_reg == $past(count_reg) + 1'b1, "record did not raise count")
    `SWRL_ASSERT_NEXT(a_pop_count, pop, count_reg == $past(count_reg) - 1'b1, "drop did not lower count")
    `SWRL_ASSERT(a_rsp_idle, $rose(rsp_valid_reg) |-> state_reg == S_IDLE, "result raised while still scanning")

endmodule

### src/sliding_window_rate_limiter_unit.sv
// top level: register port and request path of the sliding window rate limiter
//
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     timestamp
// rsp       out        rsp_valid / rsp_stall     granted, live_count
// apb       in         psel / penable / pready   paddr, pwdata, pwrite, prdata
//
// an accepted item passes S_READ, then S_SCAN, where expired stamps are dropped
// the drop scan reads one ring entry per cycle, then the decision is registered
// reset empties the ring at once; ring contents are only used once written
// a held result does not block the next transfer in; its decision waits for the slot
`timescale 1ns / 1ps

module sliding_window_rate_limiter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swrl_pkg::PADDR_W-1:0]   paddr,
    input  logic [swrl_pkg::DATA_W-1:0]    pwdata,
    output logic [swrl_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [swrl_pkg::TS_W-1:0]      timestamp,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           granted,
    output logic [swrl_pkg::LIVE_W-1:0]    live_count
);

    swrl_pkg::cfg_t     cfg_reg;
    swrl_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = swrl_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_failures   <= '1;
            cfg_reg.window_seconds <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                swrl_pkg::REG_MAX_FAILURES:
                begin
                    cfg_reg.max_failures <= pwdata[swrl_pkg::LIMIT_W-1:0];
                end
                swrl_pkg::REG_WINDOW_SECONDS:
                begin
                    cfg_reg.window_seconds <= pwdata[swrl_pkg::WINDOW_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            swrl_pkg::REG_MAX_FAILURES:
            begin
                prdata = swrl_pkg::DATA_W'(signed'(cfg_reg.max_failures));
            end
            swrl_pkg::REG_WINDOW_SECONDS:
            begin
                prdata = swrl_pkg::DATA_W'(cfg_reg.window_seconds);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    swrl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .timestamp  (timestamp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .granted    (granted),
        .live_count (live_count)
    );

endmodule
